>>> rtl/rpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types, codes and the CRC-8 step of the register packet transactor.
// ----------------------------------------------------------------------------
package rpt_pkg;

    localparam int MAX_REGS_DEF = 22;
    localparam int HDR_BYTES    = 4;
    localparam int CNT_W        = 5;     // holds a register count up to 31
    localparam logic [15:0] TIMEOUT_RST = 16'd10;
    localparam logic [0:0]  REG_TIMEOUT = 1'b0;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_WORD  = 2'd1,
        OP_BYTE  = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        K_TX   = 2'd0,
        K_WORD = 2'd1,
        K_END  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_LONG = 3'd1,
        ST_TIMEOUT  = 3'd2,
        ST_BIG_RC   = 3'd3,
        ST_CRC      = 3'd4,
        ST_ERR_CODE = 3'd5,
        ST_EMPTY    = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        J_SEND = 2'd0,
        J_READ = 2'd1,
        J_END  = 2'd2
    } t_jkind;

    typedef struct packed {
        t_jkind             kind;
        logic               code;
        logic [7:0]         page;
        logic [7:0]         offset;
        logic [CNT_W-1:0]   count;
        t_status            status;
        logic [5:0]         rc;
        logic [15:0]        fails;
    } t_job;

    // One byte through CRC-8, polynomial 0x07, MSB first.
    function automatic logic [7:0] crc8(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/rpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rpt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module rpt_queue import rpt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job       r_ent [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;

    assign o_job   = r_ent[r_rd];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (i_push) begin
                r_ent[r_wr] <= i_job;
                r_wr        <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

>>> rtl/rpt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_front
// Take input words, track the transaction and check the reply; queue jobs.
// ----------------------------------------------------------------------------
module rpt_front import rpt_pkg::*; #(
    parameter int MAX_REGS = MAX_REGS_DEF,
    parameter int WAW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1,
    parameter int RAW = $clog2(HDR_BYTES + 2 * MAX_REGS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [1:0]      i_operation,
    input  logic            i_code,
    input  logic [7:0]      i_page,
    input  logic [7:0]      i_offset,
    input  logic [5:0]      i_count,
    input  logic [15:0]     i_word,
    input  logic [7:0]      i_rx_byte,
    input  logic [15:0]     i_timeout,
    output logic            o_push,
    output t_job            o_job,
    output logic            o_ww_we,
    output logic [WAW-1:0]  o_ww_addr,
    output logic [15:0]     o_ww_data,
    output logic            o_rb_we,
    output logic [RAW-1:0]  o_rb_addr,
    output logic [7:0]      o_rb_data
);

    localparam int FW = $clog2(HDR_BYTES + 2 * MAX_REGS + 1);

    typedef enum logic [1:0] {PH_IDLE, PH_COLLECT, PH_HEAD, PH_BODY} t_phase;

    t_phase           r_phase, n_phase;
    logic             r_code, n_code;
    logic [7:0]       r_page, n_page;
    logic [7:0]       r_offset, n_offset;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_wcnt, n_wcnt;
    logic [FW-1:0]    r_fill, n_fill;
    logic [15:0]      r_timer, n_timer;
    logic [15:0]      r_fail, n_fail;
    logic [7:0]       r_hdr0, n_hdr0;
    logic [7:0]       r_hdr1, n_hdr1;
    logic [7:0]       r_crc, n_crc;

    t_op        op;
    logic [7:0] crc_b;
    logic [5:0] rc;
    logic [7:0] want;
    logic [7:0] fill_inc;
    logic       send, eval, fin, rd_ok;
    t_status    fin_st;
    logic [5:0] fin_rc;

    assign op        = t_op'(i_operation);
    assign rc        = r_hdr0[5:0];
    assign want      = 8'(HDR_BYTES) + {1'b0, rc, 1'b0};
    assign fill_inc  = 8'(r_fill) + 8'd1;
    assign crc_b     = crc8(r_crc, (r_fill == FW'(1)) ? 8'd0 : i_rx_byte);
    assign o_ww_addr = WAW'(r_wcnt);
    assign o_ww_data = i_word;
    assign o_rb_addr = RAW'(r_fill);
    assign o_rb_data = i_rx_byte;

    always_comb begin
        n_phase  = r_phase;
        n_code   = r_code;
        n_page   = r_page;
        n_offset = r_offset;
        n_count  = r_count;
        n_wcnt   = r_wcnt;
        n_fill   = r_fill;
        n_timer  = r_timer;
        n_fail   = r_fail;
        n_hdr0   = r_hdr0;
        n_hdr1   = r_hdr1;
        n_crc    = r_crc;
        send     = 1'b0;
        eval     = 1'b0;
        fin      = 1'b0;
        rd_ok    = 1'b0;
        fin_st   = ST_OK;
        fin_rc   = 6'd0;
        o_ww_we  = 1'b0;
        o_rb_we  = 1'b0;
        o_push   = 1'b0;
        o_job    = '0;

        if (i_fire) begin
            unique case (op)
                OP_START: begin
                    if (i_count > 6'(MAX_REGS)) begin
                        fin    = 1'b1;
                        fin_st = ST_TOO_LONG;
                    end else begin
                        n_code   = i_code;
                        n_page   = i_page;
                        n_offset = i_offset;
                        n_count  = CNT_W'(i_count);
                        n_wcnt   = '0;
                        if (i_code && i_count != 6'd0) begin
                            n_phase = PH_COLLECT;
                        end else begin
                            send = 1'b1;
                        end
                    end
                end
                OP_WORD: begin
                    if (r_phase == PH_COLLECT && r_wcnt < r_count) begin
                        o_ww_we = 1'b1;
                        n_wcnt  = r_wcnt + CNT_W'(1);
                        if (n_wcnt >= r_count) begin
                            send = 1'b1;
                        end
                    end
                end
                OP_BYTE: begin
                    if (r_phase == PH_HEAD || r_phase == PH_BODY) begin
                        o_rb_we = 1'b1;
                        n_fill  = FW'(fill_inc);
                        n_crc   = crc_b;
                        if (r_fill == FW'(0)) begin
                            n_hdr0 = i_rx_byte;
                        end
                        if (r_fill == FW'(1)) begin
                            n_hdr1 = i_rx_byte;
                        end
                        if (r_phase == PH_HEAD && fill_inc == 8'(HDR_BYTES)) begin
                            if (rc > 6'(MAX_REGS)) begin
                                fin    = 1'b1;
                                fin_st = ST_BIG_RC;
                                fin_rc = rc;
                            end else if (!r_code && rc != 6'd0) begin
                                n_phase = PH_BODY;
                                n_timer = 16'd0;
                            end else begin
                                eval = 1'b1;
                            end
                        end
                        if (r_phase == PH_BODY && fill_inc == want) begin
                            eval = 1'b1;
                        end
                    end
                end
                OP_TICK: begin
                    if (r_phase == PH_HEAD || r_phase == PH_BODY) begin
                        if (r_timer >= i_timeout) begin
                            fin    = 1'b1;
                            fin_st = ST_TIMEOUT;
                            fin_rc = (r_phase == PH_BODY) ? rc : 6'd0;
                        end else begin
                            n_timer = r_timer + 16'd1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // Reply checks, in priority order.
        if (eval) begin
            fin_rc = rc;
            if (crc_b != r_hdr1) begin
                fin    = 1'b1;
                fin_st = ST_CRC;
            end else if (r_hdr0[7:6] != 2'd0) begin
                fin    = 1'b1;
                fin_st = ST_ERR_CODE;
            end else if (!r_code && rc == 6'd0) begin
                fin    = 1'b1;
                fin_st = ST_EMPTY;
            end else if (!r_code) begin
                rd_ok = 1'b1;
            end else begin
                fin    = 1'b1;
                fin_st = ST_OK;
            end
        end

        if (send) begin
            o_push       = 1'b1;
            o_job.kind   = J_SEND;
            o_job.code   = n_code;
            o_job.page   = n_page;
            o_job.offset = n_offset;
            o_job.count  = n_count;
            n_phase      = PH_HEAD;
            n_fill       = '0;
            n_timer      = 16'd0;
            n_crc        = 8'd0;
        end

        if (rd_ok) begin
            o_push      = 1'b1;
            o_job.kind  = J_READ;
            o_job.count = r_count;
            o_job.rc    = rc;
            n_fail      = 16'd0;
            n_phase     = PH_IDLE;
        end

        if (fin) begin
            if (fin_st == ST_OK) begin
                n_fail = 16'd0;
            end else if (fin_st != ST_TOO_LONG && r_fail != 16'hFFFF) begin
                n_fail = r_fail + 16'd1;
            end
            o_push       = 1'b1;
            o_job.kind   = J_END;
            o_job.status = fin_st;
            o_job.rc     = fin_rc;
            o_job.fails  = n_fail;
            n_phase      = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_code   <= 1'b0;
            r_page   <= 8'd0;
            r_offset <= 8'd0;
            r_count  <= '0;
            r_wcnt   <= '0;
            r_fill   <= '0;
            r_timer  <= 16'd0;
            r_fail   <= 16'd0;
            r_hdr0   <= 8'd0;
            r_hdr1   <= 8'd0;
            r_crc    <= 8'd0;
        end else begin
            r_phase  <= n_phase;
            r_code   <= n_code;
            r_page   <= n_page;
            r_offset <= n_offset;
            r_count  <= n_count;
            r_wcnt   <= n_wcnt;
            r_fill   <= n_fill;
            r_timer  <= n_timer;
            r_fail   <= n_fail;
            r_hdr0   <= n_hdr0;
            r_hdr1   <= n_hdr1;
            r_crc    <= n_crc;
        end
    end

endmodule

>>> rtl/rpt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_back
// Run queued jobs: frame and send a packet, read back words, report the end.
// ----------------------------------------------------------------------------
module rpt_back import rpt_pkg::*; #(
    parameter int MAX_REGS = MAX_REGS_DEF,
    parameter int WAW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1,
    parameter int RAW = $clog2(HDR_BYTES + 2 * MAX_REGS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_job            i_job,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_idle,
    output logic [WAW-1:0]  o_ww_addr,
    input  logic [15:0]     i_ww_data,
    output logic [RAW-1:0]  o_rb_addr,
    input  logic [7:0]      i_rb_data,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_tx_byte,
    output logic [4:0]      o_reg_index,
    output logic [15:0]     o_reg_word,
    output logic [2:0]      o_status,
    output logic [5:0]      o_reply_count,
    output logic [15:0]     o_fails_in_row,
    output logic            o_last
);

    localparam int IW = $clog2(HDR_BYTES + 2 * MAX_REGS + 1);

    typedef enum logic [2:0] {S_IDLE, S_CRC, S_TX, S_RD, S_END} t_state;

    t_state       r_state, n_state;
    t_job         r_job;
    logic [IW-1:0] r_idx, n_idx;
    logic [7:0]   r_crc;
    logic [7:0]   r_lo;
    logic         r_ovalid;
    t_kind        r_kind;
    logic [7:0]   r_tx;
    logic [4:0]   r_ri;
    logic [15:0]  r_rw;
    logic [2:0]   r_st;
    logic [5:0]   r_rc;
    logic [15:0]  r_fl;
    logic         r_last;

    logic          slot_free;
    logic          out_load;
    logic [IW-1:0] len_m1;
    logic [IW-1:0] rd_end;
    logic [IW-1:0] wofs;
    logic [7:0]    pkt_byte;
    logic [4:0]    widx;

    assign slot_free = !r_ovalid || i_ready;
    assign out_load  = slot_free && ((r_state == S_TX) || (r_state == S_END) ||
                                     (r_state == S_RD && r_idx[0]));
    assign len_m1    = IW'(HDR_BYTES - 1) + IW'({r_job.count, 1'b0});
    assign rd_end    = IW'({r_job.count, 1'b0}) - IW'(1);
    assign wofs      = n_idx - IW'(HDR_BYTES);
    assign o_ww_addr = (n_idx >= IW'(HDR_BYTES)) ? WAW'(wofs >> 1) : '0;
    assign o_rb_addr = RAW'(n_idx + IW'(HDR_BYTES));
    assign widx      = 5'(r_idx >> 1);
    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign o_idle    = (r_state == S_IDLE);

    // Packet byte at position r_idx; the checksum slot reads as zero here.
    always_comb begin
        if (r_idx == IW'(0)) begin
            pkt_byte = {1'b0, r_job.code, 6'(r_job.count)};
        end else if (r_idx == IW'(2)) begin
            pkt_byte = r_job.page;
        end else if (r_idx == IW'(3)) begin
            pkt_byte = r_job.offset;
        end else if (r_idx == IW'(1) || !r_job.code) begin
            pkt_byte = 8'd0;
        end else begin
            pkt_byte = r_idx[0] ? i_ww_data[15:8] : i_ww_data[7:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (!i_empty) begin
                    unique case (i_job.kind)
                        J_SEND:  n_state = S_CRC;
                        J_READ:  n_state = (i_job.count != '0) ? S_RD : S_END;
                        default: n_state = S_END;
                    endcase
                end
            end
            S_CRC: begin
                if (r_idx == len_m1) begin
                    n_state = S_TX;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_TX: begin
                if (slot_free) begin
                    if (r_idx == len_m1) begin
                        n_state = S_IDLE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            S_RD: begin
                if (!r_idx[0]) begin
                    n_idx = r_idx + IW'(1);
                end else if (slot_free) begin
                    if (r_idx == rd_end) begin
                        n_state = S_END;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            S_END: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_ready && !out_load) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_job <= i_job;
                    r_crc <= 8'd0;
                end
                S_CRC: begin
                    r_crc <= crc8(r_crc, pkt_byte);
                end
                S_TX: begin
                    if (slot_free) begin
                        r_ovalid <= 1'b1;
                        r_kind   <= K_TX;
                        r_tx     <= (r_idx == IW'(1)) ? r_crc : pkt_byte;
                        r_ri     <= 5'd0;
                        r_rw     <= 16'd0;
                        r_st     <= 3'd0;
                        r_rc     <= 6'd0;
                        r_fl     <= 16'd0;
                        r_last   <= (r_idx == len_m1);
                    end
                end
                S_RD: begin
                    if (!r_idx[0]) begin
                        r_lo <= i_rb_data;
                    end else if (slot_free) begin
                        r_ovalid <= 1'b1;
                        r_kind   <= K_WORD;
                        r_tx     <= 8'd0;
                        r_ri     <= widx;
                        // zero beyond the words the reply carried
                        r_rw     <= (6'(widx) < r_job.rc) ? {i_rb_data, r_lo} : 16'd0;
                        r_st     <= 3'd0;
                        r_rc     <= 6'd0;
                        r_fl     <= 16'd0;
                        r_last   <= 1'b0;
                    end
                end
                S_END: begin
                    if (slot_free) begin
                        r_ovalid <= 1'b1;
                        r_kind   <= K_END;
                        r_tx     <= 8'd0;
                        r_ri     <= 5'd0;
                        r_rw     <= 16'd0;
                        r_st     <= r_job.status;
                        r_rc     <= r_job.rc;
                        r_fl     <= r_job.fails;
                        r_last   <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_kind         = r_kind;
    assign o_tx_byte      = r_tx;
    assign o_reg_index    = r_ri;
    assign o_reg_word     = r_rw;
    assign o_status       = r_st;
    assign o_reply_count  = r_rc;
    assign o_fails_in_row = r_fl;
    assign o_last         = r_last;

endmodule

>>> rtl/register_packet_transactor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_packet_transactor
// Client side of a register read/write packet link with CRC-8 framing.
// ----------------------------------------------------------------------------
// A front end takes one input word per cycle while it is ready: start
// requests, write words, received bytes and millisecond ticks. It tracks the
// transaction, stores write words and reply bytes in two small RAMs, runs the
// reply CRC byte by byte as bytes arrive and decides the outcome the moment
// the reply is complete or times out. Any work that produces results goes
// into a two-entry job queue. The back end takes jobs from the queue and
// produces result words through an output register. A packet job first
// computes the packet CRC (one byte a cycle from the write-word RAM), then
// sends one byte per cycle while the output register is free. A read-back
// job reads the reply RAM once per byte; an end job sends one end word. A
// start request is held off until the back end and the queue are empty;
// every other input word is taken while the queue has room.
// ----------------------------------------------------------------------------
module register_packet_transactor import rpt_pkg::*; #(
    parameter int MAX_REGS = MAX_REGS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic        i_code,
    input  logic [7:0]  i_page,
    input  logic [7:0]  i_offset,
    input  logic [5:0]  i_count,
    input  logic [15:0] i_word,
    input  logic [7:0]  i_rx_byte,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [4:0]  o_reg_index,
    output logic [15:0] o_reg_word,
    output logic [2:0]  o_status,
    output logic [5:0]  o_reply_count,
    output logic [15:0] o_fails_in_row,
    output logic        o_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WW_DEPTH = MAX_REGS;
    localparam int RB_DEPTH = HDR_BYTES + 2 * MAX_REGS;
    localparam int WAW      = (WW_DEPTH > 1) ? $clog2(WW_DEPTH) : 1;
    localparam int RAW      = $clog2(RB_DEPTH);

    logic [15:0] r_timeout;

    logic           fire;
    logic           q_push, q_pop, q_empty, q_full;
    t_job           q_in, q_out;
    logic           back_idle;
    logic           ww_we, rb_we;
    logic [WAW-1:0] ww_waddr, ww_raddr;
    logic [15:0]    ww_wdata, ww_rdata;
    logic [RAW-1:0] rb_waddr, rb_raddr;
    logic [7:0]     rb_wdata, rb_rdata;

    // Hold a start until all earlier work has drained; the stores it
    // overwrites may still be read by the back end.
    assign o_in_ready = !q_full &&
                        !(t_op'(i_operation) == OP_START && !(back_idle && q_empty));
    assign fire       = i_in_valid && o_in_ready;

    // Configuration: one register, the reply timeout in ticks.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, r_timeout} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT) begin
            r_timeout <= pwdata[15:0];
        end
    end

    rpt_front #(
        .MAX_REGS (MAX_REGS),
        .WAW      (WAW),
        .RAW      (RAW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_operation (i_operation),
        .i_code      (i_code),
        .i_page      (i_page),
        .i_offset    (i_offset),
        .i_count     (i_count),
        .i_word      (i_word),
        .i_rx_byte   (i_rx_byte),
        .i_timeout   (r_timeout),
        .o_push      (q_push),
        .o_job       (q_in),
        .o_ww_we     (ww_we),
        .o_ww_addr   (ww_waddr),
        .o_ww_data   (ww_wdata),
        .o_rb_we     (rb_we),
        .o_rb_addr   (rb_waddr),
        .o_rb_data   (rb_wdata)
    );

    rpt_ram #(.WIDTH(16), .DEPTH(WW_DEPTH), .AW(WAW)) u_ww_ram (
        .i_clk   (i_clk),
        .i_we    (ww_we),
        .i_waddr (ww_waddr),
        .i_wdata (ww_wdata),
        .i_raddr (ww_raddr),
        .o_rdata (ww_rdata)
    );

    rpt_ram #(.WIDTH(8), .DEPTH(RB_DEPTH), .AW(RAW)) u_rb_ram (
        .i_clk   (i_clk),
        .i_we    (rb_we),
        .i_waddr (rb_waddr),
        .i_wdata (rb_wdata),
        .i_raddr (rb_raddr),
        .o_rdata (rb_rdata)
    );

    rpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rpt_back #(
        .MAX_REGS (MAX_REGS),
        .WAW      (WAW),
        .RAW      (RAW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (q_out),
        .i_empty        (q_empty),
        .o_pop          (q_pop),
        .o_idle         (back_idle),
        .o_ww_addr      (ww_raddr),
        .i_ww_data      (ww_rdata),
        .o_rb_addr      (rb_raddr),
        .i_rb_data      (rb_rdata),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_kind         (o_kind),
        .o_tx_byte      (o_tx_byte),
        .o_reg_index    (o_reg_index),
        .o_reg_word     (o_reg_word),
        .o_status       (o_status),
        .o_reply_count  (o_reply_count),
        .o_fails_in_row (o_fails_in_row),
        .o_last         (o_last)
    );

endmodule

>>> tb/register_packet_transactor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_packet_transactor_test
// Self-checking bench for the register packet transactor. A queue of input
// words, built by directed and random request/reply sequences, feeds a
// clocked driver; a clocked monitor compares every result word against a
// transaction predictor kept in step with each accepted input word.
// ----------------------------------------------------------------------------
module register_packet_transactor_test;
    import rpt_pkg::*;

    localparam int MAXR      = MAX_REGS_DEF;
    localparam int BUF_BYTES = HDR_BYTES + 2 * MAXR;
    localparam int WD_LIMIT  = 5000;

    typedef enum logic [1:0] {P_IDLE, P_COLLECT, P_HEAD, P_BODY} t_phase;

    // reply shapes offered after a request
    typedef enum int {
        RP_GOOD, RP_BAD_CRC, RP_ERR_CODE, RP_BIG_RC, RP_TIMEOUT, RP_CUT, RP_EMPTY
    } t_reply;

    typedef struct {
        logic [1:0]  op;
        logic        code;
        logic [7:0]  page;
        logic [7:0]  offset;
        logic [5:0]  count;
        logic [15:0] word;
        logic [7:0]  rx_byte;
    } t_item;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [4:0]  reg_index;
        logic [15:0] reg_word;
        logic [2:0]  status;
        logic [5:0]  reply_count;
        logic [15:0] fails;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  operation = '0;
    logic        code = 1'b0;
    logic [7:0]  page = '0;
    logic [7:0]  offset = '0;
    logic [5:0]  count = '0;
    logic [15:0] word = '0;
    logic [7:0]  rx_byte = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_tx_byte;
    logic [4:0]  o_reg_index;
    logic [15:0] o_reg_word;
    logic [2:0]  o_status;
    logic [5:0]  o_reply_count;
    logic [15:0] o_fails_in_row;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    register_packet_transactor u_top (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .o_in_ready,
        .i_operation(operation), .i_code(code), .i_page(page), .i_offset(offset),
        .i_count(count), .i_word(word), .i_rx_byte(rx_byte),
        .o_out_valid, .i_out_ready(out_ready),
        .o_kind, .o_tx_byte, .o_reg_index, .o_reg_word, .o_status,
        .o_reply_count, .o_fails_in_row, .o_last,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #6 i_clk = ~i_clk;

    // stimulus and result stores
    t_item   pend_q[$];
    t_result result_q[$];
    t_item   cur;
    int      items_made = 0;
    int      err_cnt = 0;
    int      tx_idle = 0;
    int      rx_idle = 0;
    bit      tx_hold = 0;
    int      stall_req = 0;
    int      stall_seen = 0;
    int      stall_left = 0;
    int      quiet_cycles = 0;

    // predictor copy of the transaction state
    t_phase      ph = P_IDLE;
    logic        rq_code = 0;
    logic [7:0]  rq_page = 0;
    logic [7:0]  rq_off = 0;
    int          rq_cnt = 0;
    int          wcol = 0;
    logic [15:0] wwords[MAXR];
    logic [7:0]  rbytes[BUF_BYTES];
    int          rfill = 0;
    logic [15:0] wtimer = 0;
    logic [15:0] fail_run = 0;
    logic [15:0] tmo = TIMEOUT_RST;

    function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        repeat (8) r = r[7] ? {r[6:0], 1'b0} ^ 8'h07 : {r[6:0], 1'b0};
        return r;
    endfunction

    task automatic push_result(input logic [1:0] k, input logic [7:0] tb,
                               input logic [4:0] ix, input logic [15:0] w,
                               input logic [2:0] st, input logic [5:0] rc,
                               input logic [15:0] fl);
        t_result r;
        r = '{k, tb, ix, w, st, rc, fl, 1'b0};
        result_q.push_back(r);
    endtask

    // close the transaction; a rejected request leaves the failure run alone
    task automatic close_txn(input t_status st, input logic [5:0] rc);
        if (st == ST_OK)
            fail_run = 0;
        else if (st != ST_TOO_LONG && fail_run != 16'hFFFF)
            fail_run++;
        push_result(K_END, 0, 0, 0, st, rc, fail_run);
        ph = P_IDLE;
    endtask

    task automatic emit_packet();
        logic [7:0] pkt[BUF_BYTES];
        logic [7:0] c;
        logic [15:0] w;
        int len;
        len = HDR_BYTES + 2 * rq_cnt;
        c = 0;
        pkt[0] = {1'b0, rq_code, 6'(rq_cnt)};
        pkt[1] = 0;
        pkt[2] = rq_page;
        pkt[3] = rq_off;
        for (int i = 0; i < rq_cnt; i++) begin
            w = rq_code ? wwords[i] : 16'h0;
            pkt[HDR_BYTES + 2 * i]     = w[7:0];
            pkt[HDR_BYTES + 2 * i + 1] = w[15:8];
        end
        for (int i = 0; i < len; i++) c = crc_step(c, pkt[i]);
        pkt[1] = c;
        for (int i = 0; i < len; i++) push_result(K_TX, pkt[i], 0, 0, ST_OK, 0, 0);
        ph = P_HEAD;
        rfill = 0;
        wtimer = 0;
    endtask

    // judge a complete reply: CRC, status code, then empty read
    task automatic judge_reply();
        logic [5:0] rc;
        logic [7:0] c;
        logic [15:0] w;
        int len;
        rc = rbytes[0][5:0];
        len = HDR_BYTES + (rq_code == 0 ? 2 * rc : 0);
        c = 0;
        for (int i = 0; i < len && i < BUF_BYTES; i++)
            c = crc_step(c, i == 1 ? 8'h00 : rbytes[i]);
        if (c != rbytes[1]) close_txn(ST_CRC, rc);
        else if (rbytes[0][7:6] != 0) close_txn(ST_ERR_CODE, rc);
        else if (rq_code == 0 && rc == 0) close_txn(ST_EMPTY, rc);
        else begin
            if (rq_code == 0) begin
                for (int i = 0; i < rq_cnt; i++) begin
                    w = (i < rc) ? {rbytes[HDR_BYTES + 2 * i + 1], rbytes[HDR_BYTES + 2 * i]}
                                 : 16'h0;
                    push_result(K_WORD, 0, 5'(i), w, ST_OK, 0, 0);
                end
            end
            close_txn(ST_OK, rc);
        end
    endtask

    task automatic predict_item(input t_item it);
        int n0;
        int want;
        logic [5:0] rc;
        n0 = result_q.size();
        case (it.op)
            OP_START: begin
                if (it.count > MAXR) close_txn(ST_TOO_LONG, 0);
                else begin
                    rq_code = it.code;
                    rq_page = it.page;
                    rq_off  = it.offset;
                    rq_cnt  = it.count;
                    wcol    = 0;
                    if (rq_code && rq_cnt > 0) ph = P_COLLECT;
                    else emit_packet();
                end
            end
            OP_WORD: begin
                if (ph == P_COLLECT && wcol < rq_cnt) begin
                    wwords[wcol] = it.word;
                    wcol++;
                    if (wcol >= rq_cnt) emit_packet();
                end
            end
            OP_BYTE: begin
                if (ph == P_HEAD) begin
                    if (rfill < HDR_BYTES) begin
                        rbytes[rfill] = it.rx_byte;
                        rfill++;
                    end
                    if (rfill >= HDR_BYTES) begin
                        rc = rbytes[0][5:0];
                        if (rc > MAXR) close_txn(ST_BIG_RC, rc);
                        else if (rq_code == 0 && rc > 0) begin
                            ph = P_BODY;
                            wtimer = 0;
                        end else judge_reply();
                    end
                end else if (ph == P_BODY) begin
                    want = HDR_BYTES + 2 * rbytes[0][5:0];
                    if (rfill < want && rfill < BUF_BYTES) begin
                        rbytes[rfill] = it.rx_byte;
                        rfill++;
                    end
                    if (rfill >= want) judge_reply();
                end
            end
            default: begin
                if (ph == P_HEAD || ph == P_BODY) begin
                    if (wtimer >= tmo)
                        close_txn(ST_TIMEOUT, ph == P_BODY ? rbytes[0][5:0] : 6'd0);
                    else
                        wtimer++;
                end
            end
        endcase
        if (result_q.size() > n0) result_q[result_q.size() - 1].last = 1'b1;
    endtask

    // driver: advance to the next queued word once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) predict_item(cur);
            if (!in_valid || o_in_ready) begin
                if (pend_q.size() > 0 && !tx_hold && $urandom_range(0, 99) >= tx_idle) begin
                    cur = pend_q.pop_front();
                    operation <= cur.op;
                    code      <= cur.code;
                    page      <= cur.page;
                    offset    <= cur.offset;
                    count     <= cur.count;
                    word      <= cur.word;
                    rx_byte   <= cur.rx_byte;
                    in_valid  <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report(input string what);
        err_cnt++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // monitor: check each taken result word, drive ready with stalls
    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    e = result_q.pop_front();
                    if (o_kind !== e.kind)
                        report($sformatf("kind %0d, want %0d", o_kind, e.kind));
                    if (o_tx_byte !== e.tx_byte)
                        report($sformatf("tx_byte %h, want %h", o_tx_byte, e.tx_byte));
                    if (o_reg_index !== e.reg_index)
                        report($sformatf("reg_index %0d, want %0d", o_reg_index, e.reg_index));
                    if (o_reg_word !== e.reg_word)
                        report($sformatf("reg_word %h, want %h", o_reg_word, e.reg_word));
                    if (o_status !== e.status)
                        report($sformatf("status %0d, want %0d", o_status, e.status));
                    if (o_reply_count !== e.reply_count)
                        report($sformatf("reply_count %0d, want %0d", o_reply_count,
                                         e.reply_count));
                    if (o_fails_in_row !== e.fails)
                        report($sformatf("fails_in_row %0d, want %0d", o_fails_in_row, e.fails));
                    if (o_last !== e.last)
                        report($sformatf("last %b, want %b", o_last, e.last));
                end
            end
            if (stall_req != stall_seen) begin
                stall_seen <= stall_req;
                stall_left <= 300;
                out_ready  <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= rx_idle);
            end
        end
    end

    // watchdog: count busy cycles in which neither channel moves a word
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
            quiet_cycles <= 0;
        else if (in_valid || result_q.size() > 0)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic put_item(input logic [1:0] op, input logic c, input logic [5:0] n,
                            input logic [15:0] w, input logic [7:0] b);
        t_item it;
        it.op      = op;
        it.code    = c;
        it.page    = 8'($urandom);
        it.offset  = 8'($urandom);
        it.count   = n;
        it.word    = w;
        it.rx_byte = b;
        pend_q.push_back(it);
        items_made++;
    endtask

    task automatic put_start(input logic c, input logic [5:0] n, input logic [7:0] pg,
                             input logic [7:0] of);
        t_item it;
        it = '{OP_START, c, pg, of, n, 16'($urandom), 8'($urandom)};
        pend_q.push_back(it);
        items_made++;
    endtask

    // one request with write words and a reply of the chosen shape
    task automatic make_txn(input logic c, input int n, input t_reply shape,
                            input logic [15:0] wfix, input bit use_fix);
        logic [7:0] rep[BUF_BYTES];
        logic [7:0] crc;
        int rc;
        int len;
        int cut;
        put_start(c, 6'(n), 8'($urandom), 8'($urandom));
        if (c) for (int i = 0; i < n; i++)
            put_item(OP_WORD, 0, 0, use_fix ? wfix : 16'($urandom), 8'($urandom));
        if (shape == RP_BIG_RC) rc = $urandom_range(MAXR + 1, 63);
        else if (shape == RP_EMPTY) rc = 0;
        else if (c) rc = $urandom_range(0, MAXR);
        else rc = $urandom_range(1, (n + 2 > MAXR) ? MAXR : n + 2);
        len = HDR_BYTES + (c ? 0 : 2 * ((rc > MAXR) ? 0 : rc));
        rep[0] = 8'(rc);
        if (shape == RP_ERR_CODE) rep[0][7:6] = 2'($urandom_range(1, 3));
        rep[1] = 0;
        rep[2] = 8'($urandom);
        rep[3] = 8'($urandom);
        for (int i = HDR_BYTES; i < len; i++) rep[i] = 8'($urandom);
        crc = 0;
        for (int i = 0; i < len; i++) crc = crc_step(crc, rep[i]);
        rep[1] = (shape == RP_BAD_CRC) ? crc ^ 8'(1 << $urandom_range(0, 7)) : crc;
        if (shape == RP_TIMEOUT || shape == RP_CUT) begin
            cut = $urandom_range(0, len - 1);
            for (int i = 0; i < cut; i++) put_item(OP_BYTE, 0, 0, 0, rep[i]);
            if (shape == RP_TIMEOUT)
                for (int i = 0; i <= tmo; i++) put_item(OP_TICK, 0, 0, 0, 0);
        end else begin
            for (int i = 0; i < len; i++) begin
                put_item(OP_BYTE, 0, 0, 0, rep[i]);
                // hold one tick inside the reply while the timeout allows it
                if (i == 0 && tmo >= 2 && $urandom_range(0, 3) == 0)
                    put_item(OP_TICK, 0, 0, 0, 0);
            end
        end
    endtask

    task automatic make_random(input int goal);
        t_reply shape;
        int r;
        int n;
        goal = items_made + goal;
        while (items_made < goal) begin
            r = $urandom_range(0, 99);
            if (r < 82) begin
                n = ($urandom_range(0, 99) < 8) ? MAXR : $urandom_range(0, 5);
                r = $urandom_range(0, 99);
                if (r < 55) shape = RP_GOOD;
                else shape = t_reply'($urandom_range(RP_BAD_CRC, RP_EMPTY));
                if (shape == RP_TIMEOUT && tmo > 20) shape = RP_GOOD;
                make_txn($urandom_range(0, 1), n, shape, 0, 0);
            end else begin
                put_item(2'($urandom), $urandom_range(0, 1), 6'($urandom),
                         16'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pend_q.size() > 0 || in_valid || result_q.size() > 0);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tmo = data[15:0];
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle = 31;
        rx_idle = 60;

        // directed: idle noise, bounds, every reply outcome, restart while busy
        put_item(OP_WORD, 0, 0, 16'hFFFF, 0);
        put_item(OP_BYTE, 0, 0, 0, 8'hFF);
        put_item(OP_TICK, 0, 0, 0, 0);
        put_start(0, 6'd63, 8'hFF, 8'hFF);
        put_start(1, 6'(MAXR + 1), 8'h00, 8'h00);
        make_txn(1, 0, RP_GOOD, 0, 0);
        make_txn(0, 0, RP_EMPTY, 0, 0);
        make_txn(1, MAXR, RP_GOOD, 16'hFFFF, 1);
        make_txn(1, 2, RP_GOOD, 16'h0000, 1);
        make_txn(0, 3, RP_GOOD, 0, 0);
        make_txn(0, 2, RP_BAD_CRC, 0, 0);
        make_txn(1, 1, RP_ERR_CODE, 0, 0);
        make_txn(0, 1, RP_BIG_RC, 0, 0);
        make_txn(0, 2, RP_TIMEOUT, 0, 0);
        make_txn(1, 1, RP_TIMEOUT, 0, 0);
        make_txn(0, 4, RP_CUT, 0, 0);
        make_txn(0, MAXR, RP_GOOD, 0, 0);
        wait_drained();

        apb_write(3'(4 * REG_TIMEOUT), 32'd3);
        make_random(80);
        wait_drained();

        // swap idling; pause the sender halfway until all results are back
        tx_idle = 60;
        rx_idle = 31;
        apb_write(3'(4 * REG_TIMEOUT), 32'd1);
        make_random(40);
        while (pend_q.size() > 0) @(negedge i_clk);
        tx_hold = 1;
        do @(negedge i_clk); while (in_valid || result_q.size() > 0);
        tx_hold = 0;
        make_random(40);
        wait_drained();

        tx_idle = 0;
        rx_idle = 0;
        apb_write(3'(4 * REG_TIMEOUT), 32'd65535);
        make_random(70);
        wait_drained();

        // long receiver hold-off while words keep coming: fill and stall input
        apb_write(3'(4 * REG_TIMEOUT), 32'd7);
        make_random(70);
        stall_req++;
        wait_drained();

        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
